@@ hw/rtl/plsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsd_pkg: shared types and constants
// Widths, tap weights and the per-result tag for the periodic
// sixth-order second-derivative stencil.
// ----------------------------------------------------------------------------
package plsd_pkg;

	localparam int NTAP     = 7;
	localparam int HEAD_N   = 6;
	localparam int MIN_RUN  = 7;
	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 35;
	localparam int MAG_W    = 34;
	localparam int SCALE_W  = 32;
	localparam int PROD_W   = MAG_W + SCALE_W;
	localparam int VALUE_W  = 48;
	localparam int POS_W    = 12;
	localparam int WEIGHT_W = 12;

	typedef logic signed [SUM_W-1:0] term_t;

	// index 0 is the oldest sample in the window
	localparam logic signed [WEIGHT_W-1:0] TAP_WEIGHT [NTAP] = '{
		12'sd2, -12'sd27, 12'sd270, -12'sd490, 12'sd270, -12'sd27, 12'sd2
	};

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             err;
		logic             eor;
		logic             zero;
	} meta_t;

endpackage

@@ hw/rtl/plsd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsd_cell: one window cell
// Holds one sample, hands it to the older neighbor on shift and keeps
// the sample times its tap weight.
// ----------------------------------------------------------------------------
module plsd_cell
	import plsd_pkg::*;
#(
	parameter logic signed [WEIGHT_W-1:0] WEIGHT = 12'sd2
) (
	input  logic                       clk,
	input  logic                       shift,
	input  logic signed [SAMPLE_W-1:0] x_in,
	output logic signed [SAMPLE_W-1:0] x_q,
	output term_t                      term_q
);

	always_ff @(posedge clk) begin
		if (shift) begin
			x_q    <= x_in;
			term_q <= SUM_W'(x_in) * SUM_W'(WEIGHT);
		end
	end

endmodule

@@ hw/rtl/plsd_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsd_scale: sum, scale, round and saturate
// Four stages: tap sum, magnitude, product with scale, rounding shift
// with saturation into the output register.
// ----------------------------------------------------------------------------
module plsd_scale
	import plsd_pkg::*;
#(
	parameter int SCALE_FRAC = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  term_t                     terms [NTAP],
	input  meta_t                     in_meta,
	input  logic [SCALE_W-1:0]        scale,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] out_value,
	output meta_t                     out_meta
);

	localparam int RW = PROD_W + 1;
	localparam logic [RW-1:0] RND = (RW'(1) << SCALE_FRAC) >> 1;
	localparam logic [RW-1:0] MAXP = (RW'(1) << (VALUE_W - 1)) - RW'(1);
	localparam logic [RW-1:0] MAXN = RW'(1) << (VALUE_W - 1);

	logic v2_q, v3_q, v4_q, v5_q;
	logic adv2, adv3, adv4, adv5;

	term_t sum;
	term_t sum_s2;
	meta_t meta_s2, meta_s3, meta_s4, meta_s5;
	logic  neg_s3, neg_s4;
	logic [MAG_W-1:0]  mag_s3;
	logic [PROD_W-1:0] prod_s4;
	logic [SUM_W-1:0]  absv;
	logic [RW-1:0]     rnd;
	logic [RW-1:0]     q;
	logic [RW-1:0]     qs;
	logic signed [VALUE_W-1:0] val_n;
	logic signed [VALUE_W-1:0] value_s5;

	assign adv5     = !v5_q || out_ready;
	assign adv4     = !v4_q || adv5;
	assign adv3     = !v3_q || adv4;
	assign adv2     = !v2_q || adv3;
	assign in_ready = adv2;

	always_comb begin
		sum = '0;
		for (int i = 0; i < NTAP; i++) begin
			sum = sum + terms[i];
		end
	end

	assign absv = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);

	always_comb begin
		rnd = {1'b0, prod_s4} + RND;
		q   = rnd >> SCALE_FRAC;
		if (neg_s4) begin
			qs = (q > MAXN) ? MAXN : q;
		end else begin
			qs = (q > MAXP) ? MAXP : q;
		end
		if (meta_s4.zero) begin
			val_n = '0;
		end else if (neg_s4) begin
			val_n = -$signed(qs[VALUE_W-1:0]);
		end else begin
			val_n = $signed(qs[VALUE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (adv2) v2_q <= in_valid;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
			if (adv5) v5_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			sum_s2  <= sum;
			meta_s2 <= in_meta;
		end
		if (adv3 && v2_q) begin
			neg_s3  <= sum_s2[SUM_W-1];
			mag_s3  <= absv[MAG_W-1:0];
			meta_s3 <= meta_s2;
		end
		if (adv4 && v3_q) begin
			neg_s4  <= neg_s3;
			prod_s4 <= PROD_W'(mag_s3) * PROD_W'(scale);
			meta_s4 <= meta_s3;
		end
		if (adv5 && v4_q) begin
			value_s5 <= val_n;
			meta_s5  <= meta_s4;
		end
	end

	assign out_valid = v5_q;
	assign out_value = value_s5;
	assign out_meta  = meta_s5;

endmodule

@@ hw/rtl/periodic_laplacian_stencil_6th.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_laplacian_stencil_6th: periodic 7-point second derivative
//
// channel  | dir | contents
// s_*      | in  | tdata[23:0] sample, tlast last sample of run
// m_*      | out | tdata[47:0] value, [59:48] position, tuser run_error,
//          |     | tlast end_of_run
// scale_*  | in  | write enable and 32-bit scale value
//
// One sample per cycle while s_tready is high; a sample passes the cell row and the
// plsd_scale stages before m_tvalid rises. A good run's last sample is followed by
// wrap-around with s_tready low while the saved head samples pass down the cell row.
// The stages stall independently, so bubbles close while m_tready is low.
// Reset clears run count, overrun flag and all stage valids; scale = 65536.
// ----------------------------------------------------------------------------
module periodic_laplacian_stencil_6th
	import plsd_pkg::*;
#(
	parameter int MAX_POINTS = 4096,
	parameter int SCALE_FRAC = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,   // [23:0] sample
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [63:0]         m_tdata,   // [47:0] value, [59:48] position, zero fill
	output logic                m_tuser,   // [0] run_error
	output logic                m_tlast,
	input  logic                scale_we,
	input  logic [SCALE_W-1:0]  scale_wdata
);

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int PCW = (CW > POS_W) ? CW : POS_W;
	localparam logic [2:0] LAST_DIDX = 3'(HEAD_N - 1);

	logic [SCALE_W-1:0] scale_q;
	logic [CW-1:0]      cnt_q, nn_q, cnt_new;
	logic               ovf_q, drain_q;
	logic [2:0]         didx_q;
	logic signed [SAMPLE_W-1:0] head_q [HEAD_N];

	logic  v1_q;
	meta_t meta_s1;
	logic  adv1, s2_ready;
	logic  in_acc, take, ovf_new, run_ok, shift;
	logic [PCW-1:0] pos_norm, pos_drain;
	logic signed [SAMPLE_W-1:0] chain_in;
	logic signed [SAMPLE_W-1:0] x [NTAP];
	term_t terms [NTAP];

	logic                      out_valid;
	logic signed [VALUE_W-1:0] out_value;
	meta_t                     out_meta;

	assign adv1     = !v1_q || s2_ready;
	assign s_tready = adv1 && !drain_q;
	assign in_acc   = s_tvalid && s_tready;

	assign take     = !ovf_q && (cnt_q != CW'(MAX_POINTS));
	assign cnt_new  = take ? cnt_q + 1'b1 : cnt_q;
	assign ovf_new  = !take;
	assign run_ok   = !ovf_new && (cnt_new >= CW'(MIN_RUN));
	assign pos_norm = PCW'(cnt_new) - PCW'(4);
	assign pos_drain = (didx_q < 3'd3) ? PCW'(nn_q) - PCW'(3) + PCW'(didx_q)
	                                   : PCW'(didx_q) - PCW'(3);

	assign shift    = (in_acc && take) || (drain_q && adv1);
	assign chain_in = drain_q ? head_q[didx_q] : $signed(s_tdata);

	genvar j;
	generate
		for (j = 0; j < NTAP; j++) begin : g_cell
			if (j == NTAP - 1) begin : g_top
				plsd_cell #(.WEIGHT(TAP_WEIGHT[j])) u_cell (
					.clk    (clk),
					.shift  (shift),
					.x_in   (chain_in),
					.x_q    (x[j]),
					.term_q (terms[j])
				);
			end else begin : g_mid
				plsd_cell #(.WEIGHT(TAP_WEIGHT[j])) u_cell (
					.clk    (clk),
					.shift  (shift),
					.x_in   (x[j+1]),
					.x_q    (x[j]),
					.term_q (terms[j])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(65536);
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
			didx_q  <= '0;
			v1_q    <= 1'b0;
		end else begin
			if (scale_we) scale_q <= scale_wdata;
			if (drain_q && adv1) begin
				v1_q   <= 1'b1;
				didx_q <= didx_q + 3'd1;
				if (didx_q == LAST_DIDX) drain_q <= 1'b0;
			end else if (in_acc) begin
				if (s_tlast) begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					v1_q    <= 1'b1;
					drain_q <= run_ok;
					didx_q  <= '0;
				end else begin
					cnt_q <= cnt_new;
					ovf_q <= ovf_new;
					v1_q  <= run_ok;
				end
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && take && (cnt_q < CW'(HEAD_N))) begin
			head_q[cnt_q[2:0]] <= $signed(s_tdata);
		end
		if (in_acc && s_tlast) nn_q <= cnt_new;
		if (drain_q && adv1) begin
			meta_s1 <= '{pos: pos_drain[POS_W-1:0], err: 1'b0,
			             eor: (didx_q == LAST_DIDX), zero: 1'b0};
		end else if (in_acc) begin
			meta_s1 <= '{pos: run_ok ? pos_norm[POS_W-1:0] : '0,
			             err: s_tlast && !run_ok,
			             eor: s_tlast && !run_ok,
			             zero: !run_ok};
		end
	end

	plsd_scale #(.SCALE_FRAC(SCALE_FRAC)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1_q),
		.in_ready  (s2_ready),
		.terms     (terms),
		.in_meta   (meta_s1),
		.scale     (scale_q),
		.out_valid (out_valid),
		.out_ready (m_tready),
		.out_value (out_value),
		.out_meta  (out_meta)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {4'b0, out_meta.pos, out_value};
	assign m_tuser  = out_meta.err;
	assign m_tlast  = out_meta.eor;

	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !s_tready)
		else $error("input taken during wrap-around");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("run count beyond limit");

	a_drain_index: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> didx_q <= LAST_DIDX)
		else $error("wrap-around index out of range");

	a_error_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[47:0] == 48'd0))
		else $error("error item not a zero end of run");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drain_q) |-> (cnt_q == '0 && !ovf_q && v1_q))
		else $error("wrap-around started without run reset");

endmodule
